### rtl/dtdps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtdps_pkg
// Constants and register codes for the dual-tap delay-line pitch shifter.
// ----------------------------------------------------------------------------
package dtdps_pkg;

	// default sizes
	localparam int DELAY_DEPTH_DEF  = 2048;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int PHASE_BITS_DEF   = 24;

	// delay length register
	localparam int                  LEN_REG_W = 12;
	localparam logic [LEN_REG_W-1:0] LEN_RESET = 12'd1440;

	// configuration register index codes
	localparam int                  CFG_IDX_W        = 4;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC    = 4'd1;

endpackage
`default_nettype wire

### rtl/dual_tap_delay_pitch_shifter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_tap_delay_pitch_shifter
// Two-tap delay-line pitch shifter with triangular crossfade envelopes.
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_ready carries one signed sample per item, the
//   output channel out_valid/out_ready returns one shifted sample per item.
//   delay_length and phase_increment are written through cfg_we/cfg_index/
//   cfg_data while the block is idle; the user keeps to this, the block does not enforce it.
//   Each item runs through one shared multiplier and one compare/subtract
//   remainder step under a small sequencer: per tap one phase*length product,
//   a ceiling step, an offset step, AW+2 remainder steps (AW = address bits of
//   the delay line), one memory read and one envelope*sample product.
//   A new item is accepted only once the previous one has left the final
//   step and the block is idle again. The single-port delay memory serves
//   both tap reads and the write of the new sample.
//   The result sits in an output register: the next item is accepted and
//   processed while it waits, and only the final step stalls until the
//   receiver takes the previous result.
//   Reset clears pointer, phase and registers to their defaults at once; the
//   delay line reads as zero through a fill count, no clearing pass needed.
// ----------------------------------------------------------------------------
module dual_tap_delay_pitch_shifter #(
	parameter int DELAY_DEPTH  = dtdps_pkg::DELAY_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = dtdps_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_BITS   = dtdps_pkg::PHASE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_in,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]          sample_out,
	input  wire logic                               cfg_we,
	input  wire logic [dtdps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [PHASE_BITS-1:0]              cfg_data
);

	localparam int AW   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
	localparam int LW   = $clog2(DELAY_DEPTH + 1);
	localparam int VW   = AW + 2;
	localparam int CW   = $clog2(VW + 1);
	localparam int MW   = (SAMPLE_WIDTH > LW + 1) ? SAMPLE_WIDTH : LW + 1;
	localparam int PW   = PHASE_BITS + 2 + MW;
	localparam int ACCW = PHASE_BITS + SAMPLE_WIDTH + 2;
	localparam int OW   = ACCW - PHASE_BITS;

	localparam logic [PHASE_BITS-1:0] PH_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
	localparam logic [LW+PHASE_BITS:0] CEIL_BIAS =
		(LW+PHASE_BITS+1)'((64'd1 << (PHASE_BITS - 1)) - 64'd1);
	localparam logic signed [ACCW-1:0] ROUND_HALF =
		$signed(ACCW'(64'd1 << (PHASE_BITS - 1)));
	localparam logic signed [OW-1:0] SMP_MAX =
		$signed(OW'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1));
	localparam logic signed [OW-1:0] SMP_MIN = -SMP_MAX - OW'(1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULP,
		S_CEIL,
		S_VAL,
		S_DIV,
		S_RD,
		S_MULE,
		S_ACC,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [dtdps_pkg::LEN_REG_W-1:0] delay_length_q;
	logic [PHASE_BITS-1:0]           phase_inc_q;

	// item state
	logic [AW-1:0]                   wp_q;
	logic [AW:0]                     fill_q;
	logic [PHASE_BITS-1:0]           phase_q;
	logic [LW-1:0]                   len_q;
	logic signed [SAMPLE_WIDTH-1:0]  sample_q;
	logic                            tap_q;
	logic signed [PW-1:0]            prod_q;
	logic [LW:0]                     m_q;
	logic [VW-1:0]                   v_q;
	logic [LW-1:0]                   rem_q;
	logic [CW-1:0]                   cnt_q;
	logic signed [ACCW-1:0]          acc_q;
	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  sample_out_q;

	// delay memory
	logic signed [SAMPLE_WIDTH-1:0]  mem [DELAY_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0]  rd_data_q;
	logic                            rd_hit_q;

	logic [LW-1:0]                   len_eff;
	logic [PHASE_BITS-1:0]           phase_t;
	logic [PHASE_BITS:0]             env_diff;
	logic [PHASE_BITS:0]             env_t;
	logic signed [SAMPLE_WIDTH-1:0]  tap_val;
	logic signed [PHASE_BITS+1:0]    mul_a;
	logic signed [MW-1:0]            mul_b;
	logic signed [PW-1:0]            mul_p;
	logic [LW+PHASE_BITS:0]          ceil_sum;
	logic [VW-1:0]                   v_next;
	logic [LW:0]                     trial;
	logic                            trial_ge;
	logic [LW-1:0]                   rem_next;
	logic [AW-1:0]                   rd_addr;
	logic signed [ACCW-1:0]          rnd;
	logic signed [OW-1:0]            y_full;
	logic signed [SAMPLE_WIDTH-1:0]  y_sat;
	logic [AW:0]                     wp_inc;
	logic                            wp_wrap;
	logic                            out_free;
	logic                            in_fire;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign out_free   = !out_valid_q || out_ready;

	// effective length: zero acts as one, clamp to the line depth
	always_comb begin
		if (delay_length_q == '0) begin
			len_eff = LW'(1);
		end else if (32'(delay_length_q) > 32'(DELAY_DEPTH)) begin
			len_eff = LW'(DELAY_DEPTH);
		end else begin
			len_eff = LW'(delay_length_q);
		end
	end

	// tap phase and triangular envelope
	assign phase_t  = tap_q ? (phase_q + PH_HALF) : phase_q;
	assign env_diff = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, phase_t};
	assign env_t    = phase_t[PHASE_BITS-1] ? {env_diff[PHASE_BITS-1:0], 1'b0}
	                                        : {phase_t, 1'b0};

	assign tap_val = rd_hit_q ? rd_data_q : '0;

	// shared multiplier: phase*length for the index, envelope*sample for the mix
	always_comb begin
		if (state_q == S_MULP) begin
			mul_a = $signed({2'b00, phase_t});
			mul_b = $signed(MW'(len_q));
		end else begin
			mul_a = $signed({1'b0, env_t});
			mul_b = MW'(tap_val);
		end
	end
	assign mul_p = mul_a * mul_b;

	// ceil(len*p / 2^(PHASE_BITS-1)), then offset by two lengths to stay positive
	assign ceil_sum = {1'b0, prod_q[LW+PHASE_BITS-1:0]} + CEIL_BIAS;
	assign v_next   = VW'(wp_q) + VW'({len_q, 1'b0}) - VW'(m_q);

	// restoring remainder step, one bit a cycle
	assign trial    = {rem_q, v_q[VW-1]};
	assign trial_ge = (trial >= {1'b0, len_q});
	assign rem_next = trial_ge ? LW'(trial - {1'b0, len_q}) : trial[LW-1:0];
	assign rd_addr  = rem_q[AW-1:0];

	// round half up, saturate
	assign rnd    = acc_q + ROUND_HALF;
	assign y_full = rnd[ACCW-1:PHASE_BITS];
	always_comb begin
		if (y_full > SMP_MAX) begin
			y_sat = SAMPLE_WIDTH'(SMP_MAX);
		end else if (y_full < SMP_MIN) begin
			y_sat = SAMPLE_WIDTH'(SMP_MIN);
		end else begin
			y_sat = SAMPLE_WIDTH'(y_full);
		end
	end

	assign wp_inc  = {1'b0, wp_q} + (AW+1)'(1);
	assign wp_wrap = ((AW+2)'(wp_inc) >= (AW+2)'(len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			delay_length_q <= dtdps_pkg::LEN_RESET;
			phase_inc_q    <= '0;
			wp_q           <= '0;
			fill_q         <= '0;
			phase_q        <= '0;
			len_q          <= '0;
			sample_q       <= '0;
			tap_q          <= 1'b0;
			prod_q         <= '0;
			m_q            <= '0;
			v_q            <= '0;
			rem_q          <= '0;
			cnt_q          <= '0;
			acc_q          <= '0;
			out_valid_q    <= 1'b0;
			sample_out_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dtdps_pkg::REG_DELAY_LENGTH: begin
						delay_length_q <= cfg_data[dtdps_pkg::LEN_REG_W-1:0];
					end
					dtdps_pkg::REG_PHASE_INC: begin
						phase_inc_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end

			// the final step raises the flag itself when it hands over a new item
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sample_q <= sample_in;
						len_q    <= len_eff;
						tap_q    <= 1'b0;
						acc_q    <= '0;
						state_q  <= S_MULP;
					end
				end
				S_MULP: begin
					prod_q  <= mul_p;
					state_q <= S_CEIL;
				end
				S_CEIL: begin
					m_q     <= ceil_sum[LW+PHASE_BITS-1:PHASE_BITS-1];
					state_q <= S_VAL;
				end
				S_VAL: begin
					v_q     <= v_next;
					rem_q   <= '0;
					cnt_q   <= CW'(VW);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_next;
					v_q   <= {v_q[VW-2:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MULE;
				end
				S_MULE: begin
					prod_q  <= mul_p;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + $signed(prod_q[ACCW-1:0]);
					if (tap_q) begin
						state_q <= S_DONE;
					end else begin
						tap_q   <= 1'b1;
						state_q <= S_MULP;
					end
				end
				S_DONE: begin
					if (out_free) begin
						sample_out_q <= y_sat;
						out_valid_q  <= 1'b1;
						wp_q         <= wp_wrap ? '0 : wp_inc[AW-1:0];
						if (wp_inc > fill_q) begin
							fill_q <= wp_inc;
						end
						phase_q <= phase_q + phase_inc_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// delay memory: one port, two tap reads then the write of the new sample
	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			rd_data_q <= mem[rd_addr];
			rd_hit_q  <= ({1'b0, rd_addr} < fill_q);
		end
		if (state_q == S_DONE && out_free) begin
			mem[wp_q] <= sample_q;
		end
	end

	// a result appears only from the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final step");

	// a tap read address always lies inside the active length
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> ({1'b0, rem_q} < {1'b0, len_q}))
		else $error("tap index outside the delay length");

	// the fill mark never passes the depth of the line
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fill_q) <= 32'(DELAY_DEPTH)))
		else $error("fill count beyond the delay depth");

	// an accepted item starts the index product on the first tap
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_MULP) && !tap_q)
		else $error("accepted item did not start the sequence");

	// the remainder loop always has steps left while it runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q != '0))
		else $error("remainder step counter ran out");

endmodule
`default_nettype wire
